### hdl/limb_stream_right_shift_halve_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro takes a label, clock, active-low reset, the check and a message.
`ifndef LIMB_STREAM_RIGHT_SHIFT_HALVE_MACROS_SVH
`define LIMB_STREAM_RIGHT_SHIFT_HALVE_MACROS_SVH
`ifndef SYNTHESIS
`define LSRH_ASSERT_NOW(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);
`define LSRH_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define LSRH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define LSRH_ASSERT_NOW(lbl, ck, rn, cond, msg)
`define LSRH_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`define LSRH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

### hdl/lsrh_pkg.sv
`default_nettype none
package lsrh_pkg;

    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    // register indexes (paddr[4:3])
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_SHIFT = 2'd1;
    localparam logic [1:0] REG_FILL  = 2'd2;

    // mode codes; the unused code behaves as shift
    localparam logic [1:0] MODE_SHIFT = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_SUB   = 2'd2;

    typedef struct packed {
        logic [63:0] limb_a;
        logic [63:0] limb_b;
        logic        last;
    } req_item_t;

    typedef struct packed {
        logic [63:0] result_limb;
        logic        result_last;
        logic [63:0] out_bits;
    } rsp_item_t;

    typedef struct packed {
        logic push0;
        logic push1;
    } q_push_t;

endpackage
`default_nettype wire

### hdl/lsrh_limb_alu.sv
`default_nettype none
// One limb step: shift, add-halve or sub-halve pieces.
module lsrh_limb_alu #(
    parameter int LIMB_WIDTH = 64
) (
    input  wire logic [1:0]            mode,
    input  wire logic [5:0]            shift_amount,
    input  wire logic [LIMB_WIDTH-1:0] fill,
    input  wire logic [LIMB_WIDTH-1:0] a,
    input  wire logic [LIMB_WIDTH-1:0] b,
    input  wire logic                  cin,
    output logic      [LIMB_WIDTH-1:0] part,
    output logic      [LIMB_WIDTH-1:0] top,
    output logic      [LIMB_WIDTH-1:0] first_bits,
    output logic      [LIMB_WIDTH-1:0] tail,
    output logic                       cnew
);

    localparam int LW = LIMB_WIDTH;

    logic [LW:0]   sum;
    logic [LW:0]   diff;
    logic [LW-1:0] r;
    logic          c;
    logic [5:0]    s;
    logic [6:0]    rs;
    logic [LW-1:0] hi_mask;

    always_comb
    begin
        sum     = {1'b0, a} + {1'b0, b} + {{LW{1'b0}}, cin};
        diff    = {1'b0, a} - {1'b0, b} - {{LW{1'b0}}, cin};
        // counts of LW or more saturate to LW-1
        s       = (int'(shift_amount) > LW - 1) ? 6'(LW - 1) : shift_amount;
        rs      = 7'(LW) - {1'b0, s};
        hi_mask = {LW{1'b1}} << rs;

        r = sum[LW-1:0];
        c = sum[LW];
        if (mode == lsrh_pkg::MODE_SUB)
        begin
            r = diff[LW-1:0];
            c = diff[LW];
        end

        case (mode)
            lsrh_pkg::MODE_ADD, lsrh_pkg::MODE_SUB:
            begin
                part       = {1'b0, r[LW-1:1]};
                top        = {r[0], {(LW-1){1'b0}}};
                first_bits = {{(LW-1){1'b0}}, r[0]};
                tail       = {c, {(LW-1){1'b0}}};
                cnew       = c;
            end
            default:
            begin
                cnew = 1'b0;
                if (s == 6'd0)
                begin
                    part       = a;
                    top        = '0;
                    first_bits = '0;
                    tail       = '0;
                end
                else
                begin
                    part       = a >> s;
                    top        = a << rs;
                    first_bits = a << rs;
                    tail       = fill & hi_mask;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/lsrh_out_queue.sv
`default_nettype none
`include "limb_stream_right_shift_halve_macros.svh"
// Three-entry result queue; takes up to two results per cycle.
module lsrh_out_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lsrh_pkg::q_push_t   push,
    input  wire lsrh_pkg::rsp_item_t item0,
    input  wire lsrh_pkg::rsp_item_t item1,
    output logic [1:0]               space,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output lsrh_pkg::rsp_item_t      rsp
);

    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic [1:0]          head_reg;
    logic [1:0]          head_next;
    logic                pop;
    logic [2:0]          tail_sum;
    logic [1:0]          tail0;
    logic [1:0]          tail1;
    lsrh_pkg::rsp_item_t slot_reg [3];

    // slot after p, wrapping at three
    function automatic logic [1:0] next_slot(input logic [1:0] p);
        return (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    always_comb
    begin
        pop        = (count_reg != 2'd0) && rsp_ready;
        tail_sum   = {1'b0, head_reg} + {1'b0, count_reg};
        tail0      = (tail_sum >= 3'd3) ? 2'(tail_sum - 3'd3) : tail_sum[1:0];
        tail1      = next_slot(tail0);
        count_next = count_reg - {1'b0, pop} + {1'b0, push.push0} + {1'b0, push.push1};
        head_next  = pop ? next_slot(head_reg) : head_reg;
        space      = 2'd3 - count_reg;
        rsp_valid  = count_reg != 2'd0;
        rsp        = slot_reg[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            head_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            slot_reg[tail0] <= item0;
        end
        if (push.push1)
        begin
            slot_reg[tail1] <= item1;
        end
    end

    `LSRH_ASSERT_NOW(a_head_range, clk, rst_n, head_reg != 2'd3, "queue head out of range")
    `LSRH_ASSERT_IMPL(a_push_order, clk, rst_n, push.push1, push.push0, "second push without first")
    `LSRH_ASSERT_IMPL(a_no_overflow, clk, rst_n, push.push0, count_reg != 2'd3, "push into full queue")

endmodule
`default_nettype wire

### hdl/limb_stream_right_shift_halve.sv
`default_nettype none
`include "limb_stream_right_shift_halve_macros.svh"
// Streaming multi-limb right shift / halving unit. Operands arrive one limb per
// request, least significant first, with last on the top limb. mode 0 shifts A
// right by shift_amount (top bits filled from carry_fill, zero count copies A);
// mode 1 gives (A+B+c)>>1 and mode 2 gives (A-B-b)>>1, with bit 0 of carry_fill
// as the initial carry or borrow. Each result limb is sent one limb late, so a
// multi-limb operand's last request yields two result limbs and a single-limb
// operand yields one; the final limb carries out_bits. Rate: one limb per
// cycle when the result side keeps up; the three-entry result queue absorbs
// the extra result of a last limb, so back-to-back requests never wait on it.
// A request is registered, then its results pass the result queue. The rate
// is set by the loop through the held limb and carry registers.
// Registers (64-bit APB, address 8*i): 0 mode, 8 shift_amount, 16 carry_fill;
// write them only while the block is idle.
module limb_stream_right_shift_halve #(
    parameter int LIMB_WIDTH = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request side
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire lsrh_pkg::req_item_t               req,
    // result side
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output lsrh_pkg::rsp_item_t                    rsp,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lsrh_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [lsrh_pkg::DATA_W-1:0]       pwdata,
    output logic      [lsrh_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready
);

    localparam int LW = LIMB_WIDTH;

    // configuration registers
    logic [1:0]  mode_reg;
    logic [5:0]  shift_reg;
    logic [63:0] fill_reg;
    logic        cfg_wr;

    // input register
    logic                in_valid_reg;
    logic                in_valid_next;
    lsrh_pkg::req_item_t in_item_reg;
    logic                accept;

    // per-operand state
    logic [LW-1:0] held_partial_reg;
    logic [LW-1:0] held_partial_next;
    logic          running_carry_reg;
    logic          running_carry_next;
    logic          at_first_reg;
    logic          at_first_next;
    logic [LW-1:0] saved_out_bits_reg;
    logic [LW-1:0] saved_out_bits_next;

    // datapath
    logic          cin;
    logic [LW-1:0] part;
    logic [LW-1:0] top;
    logic [LW-1:0] first_bits;
    logic [LW-1:0] tail;
    logic          cnew;
    logic [LW-1:0] sob;
    logic [1:0]    need;
    logic [1:0]    space;
    logic          consume;

    lsrh_pkg::q_push_t   push;
    lsrh_pkg::rsp_item_t item0;
    lsrh_pkg::rsp_item_t item1;
    lsrh_pkg::rsp_item_t mid_item;
    lsrh_pkg::rsp_item_t fin_item;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= lsrh_pkg::MODE_SHIFT;
            shift_reg <= 6'd0;
            fill_reg  <= 64'd0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:3])
                lsrh_pkg::REG_MODE:  mode_reg  <= pwdata[1:0];
                lsrh_pkg::REG_SHIFT: shift_reg <= pwdata[5:0];
                lsrh_pkg::REG_FILL:  fill_reg  <= pwdata;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            lsrh_pkg::REG_MODE:  prdata = 64'(mode_reg);
            lsrh_pkg::REG_SHIFT: prdata = 64'(shift_reg);
            lsrh_pkg::REG_FILL:  prdata = fill_reg;
            default:             prdata = 64'd0;
        endcase
    end

    // ---------------- input register ----------------
    // A request is taken whenever the register is empty or drains this cycle;
    // ready depends on local registers only, never on rsp_ready.
    assign req_ready = !in_valid_reg || consume;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= req;
        end
    end

    // ---------------- limb step ----------------
    // carry/borrow seed comes from carry_fill bit 0 on the first limb
    assign cin = at_first_reg ? fill_reg[0] : running_carry_reg;

    lsrh_limb_alu #(
        .LIMB_WIDTH (LIMB_WIDTH)
    ) u_alu (
        .mode         (mode_reg),
        .shift_amount (shift_reg),
        .fill         (fill_reg[LW-1:0]),
        .a            (in_item_reg.limb_a[LW-1:0]),
        .b            (in_item_reg.limb_b[LW-1:0]),
        .cin          (cin),
        .part         (part),
        .top          (top),
        .first_bits   (first_bits),
        .tail         (tail),
        .cnew         (cnew)
    );

    always_comb
    begin
        // out_bits of an operand are fixed by its first limb
        sob = at_first_reg ? first_bits : saved_out_bits_reg;

        mid_item.result_limb = 64'(held_partial_reg | top);
        mid_item.result_last = 1'b0;
        mid_item.out_bits    = 64'd0;

        fin_item.result_limb = 64'(part | tail);
        fin_item.result_last = 1'b1;
        fin_item.out_bits    = 64'(sob);

        // results this limb produces: pending limb unless first, final if last
        need    = {1'b0, !at_first_reg} + {1'b0, in_item_reg.last};
        consume = in_valid_reg && (space >= need);

        push.push0 = consume && (!at_first_reg || in_item_reg.last);
        push.push1 = consume && !at_first_reg && in_item_reg.last;
        item0      = at_first_reg ? fin_item : mid_item;
        item1      = fin_item;

        held_partial_next   = held_partial_reg;
        running_carry_next  = running_carry_reg;
        at_first_next       = at_first_reg;
        saved_out_bits_next = saved_out_bits_reg;
        if (consume)
        begin
            held_partial_next   = part;
            running_carry_next  = cnew;
            at_first_next       = in_item_reg.last;
            saved_out_bits_next = sob;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_partial_reg   <= '0;
            running_carry_reg  <= 1'b0;
            at_first_reg       <= 1'b1;
            saved_out_bits_reg <= '0;
        end
        else
        begin
            held_partial_reg   <= held_partial_next;
            running_carry_reg  <= running_carry_next;
            at_first_reg       <= at_first_next;
            saved_out_bits_reg <= saved_out_bits_next;
        end
    end

    // ---------------- result queue ----------------
    lsrh_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item0     (item0),
        .item1     (item1),
        .space     (space),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    `LSRH_ASSERT_NEXT(a_hold_item, clk, rst_n, in_valid_reg && !consume, in_valid_reg && $stable(in_item_reg), "waiting request lost or changed")
    `LSRH_ASSERT_IMPL(a_pair_room, clk, rst_n, push.push1, space >= 2'd2, "result pair without room")
    `LSRH_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !in_valid_reg, req_ready, "empty stage not ready")

endmodule
`default_nettype wire
